// ----- hdl/ibd_pkg.sv -----
// Shared constants and types of the IBD moment estimator.
package ibd_pkg;

  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int ONE_Q      = 1 << FRAC_BITS;
  localparam int COEF_W     = FRAC_BITS + 1;
  localparam int NUM_W      = COUNT_BITS + FRAC_BITS;
  localparam int DEN_W      = COUNT_BITS + 2;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_A00 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_A01 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_A02 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_A11 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_A12 = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TRI = 3'd5;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;

endpackage

// ----- hdl/ibd_moment_estimator_top.sv -----
// Top level of the IBD method-of-moments estimator pipeline.
//
// Channel  Ports                                         Handshake
// input    count_share0..2                               start, busy
// result   prob_ibd0, prob_ibd1, result_valid            done
// config   cfg_addr, cfg_wdata                           cfg_we
//
// A transfer is taken in every cycle; busy stays low.
// done rises once the transfer has passed the five chained 40-stage dividers
// and the registers between them; the result is on the ports for one cycle.
// Reset clears stage valid bits and configuration registers, not result_valid.
// The receiver cannot stall, so the pipeline advances in every cycle.
module ibd_moment_estimator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ibd_pkg::COUNT_BITS-1:0]    count_share0,
  input  logic [ibd_pkg::COUNT_BITS-1:0]    count_share1,
  input  logic [ibd_pkg::COUNT_BITS-1:0]    count_share2,
  input  logic                              cfg_we,
  input  logic [ibd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ibd_pkg::COEF_W-1:0]        cfg_wdata,
  output logic                              done,
  output logic [ibd_pkg::COEF_W-1:0]        prob_ibd0,
  output logic [ibd_pkg::COEF_W-1:0]        prob_ibd1,
  output logic                              result_valid
);

  localparam int FB   = ibd_pkg::FRAC_BITS;
  localparam int CB   = ibd_pkg::COUNT_BITS;
  localparam int CW   = ibd_pkg::COEF_W;
  localparam int NW   = ibd_pkg::NUM_W;
  localparam int DW   = ibd_pkg::DEN_W;
  localparam int L    = ibd_pkg::NUM_W;
  localparam int K0_W = CW + 1;
  localparam int MW   = K0_W + CW;
  localparam int SW   = FB + 4;
  localparam int WW   = NW + 2;
  localparam int PW   = 2 * SW;

  localparam logic [CW-1:0]        ONE_C  = {1'b1, {FB{1'b0}}};
  localparam logic [K0_W-1:0]      TWO_K  = {1'b1, {(FB+1){1'b0}}};
  localparam ibd_pkg::num_t        ONE_N  = ibd_pkg::num_t'(ibd_pkg::ONE_Q);
  localparam ibd_pkg::num_t        TWO_N  = ibd_pkg::num_t'(2 * ibd_pkg::ONE_Q);
  localparam logic signed [SW-1:0] ONE_S  = SW'(ibd_pkg::ONE_Q);
  localparam logic signed [SW-1:0] TWO_S  = SW'(2 * ibd_pkg::ONE_Q);
  localparam logic signed [WW-1:0] ONE_W  = WW'(ibd_pkg::ONE_Q);
  localparam logic signed [WW-1:0] MTWO_W = -WW'(2 * ibd_pkg::ONE_Q);

  typedef struct packed {
    logic          bad;
    logic [CW-1:0] f1;
    logic [CW-1:0] f2;
  } ctxb_t;

  typedef struct packed {
    logic            bad;
    logic [K0_W-1:0] k0;
    logic [CW-1:0]   f2;
    logic [K0_W-1:0] m2s;
    logic            neg;
  } ctxk_t;

  typedef struct packed {
    logic                 bad;
    logic signed [SW-1:0] k0;
    logic                 k1neg;
    logic [CW-1:0]        k1v;
    logic                 k2neg;
    logic                 sneg;
    logic                 szero;
  } ctxr1_t;

  typedef struct packed {
    logic                 bad;
    logic signed [SW-1:0] k0;
    logic [CW-1:0]        k1;
    logic                 k2neg;
    logic                 sneg;
    logic                 szero;
  } ctxr2_t;

  function automatic logic [SW-1:0] mag_s(input logic signed [SW-1:0] v);
    return v[SW-1] ? -v : v;
  endfunction

  // Configuration registers.
  logic [CW-1:0] a00, a01, a02, a11, a12;
  logic          tri_on;
  logic [CW-1:0] coef_sat;

  assign coef_sat = (cfg_wdata > ONE_C) ? ONE_C : cfg_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      a00    <= '0;
      a01    <= '0;
      a02    <= '0;
      a11    <= '0;
      a12    <= '0;
      tri_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ibd_pkg::REG_A00: a00 <= coef_sat;
        ibd_pkg::REG_A01: a01 <= coef_sat;
        ibd_pkg::REG_A02: a02 <= coef_sat;
        ibd_pkg::REG_A11: a11 <= coef_sat;
        ibd_pkg::REG_A12: a12 <= coef_sat;
        ibd_pkg::REG_TRI: tri_on <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign busy = 1'b0;

  // Input stage.
  logic          s0_v;
  logic [CB-1:0] s0_c0, s0_c1, s0_c2;
  ibd_pkg::den_t n_sum;
  logic          bad0;

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else     s0_v <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    s0_c0 <= count_share0;
    s0_c1 <= count_share1;
    s0_c2 <= count_share2;
  end

  assign n_sum = DW'(s0_c0) + DW'(s0_c1) + DW'(s0_c2);
  assign bad0  = (n_sum == '0) || (a00 == '0) || (a11 == '0);

  // Fractions of the total count.
  ibd_pkg::num_t qa0, qa1, qa2;
  logic [L-1:0]  va, ba;

  ibd_div u_div_f0 (.clk(clk), .num({s0_c0, {FB{1'b0}}}), .den(n_sum), .quo(qa0));
  ibd_div u_div_f1 (.clk(clk), .num({s0_c1, {FB{1'b0}}}), .den(n_sum), .quo(qa1));
  ibd_div u_div_f2 (.clk(clk), .num({s0_c2, {FB{1'b0}}}), .den(n_sum), .quo(qa2));

  always_ff @(posedge clk) begin
    if (rst) va <= '0;
    else     va <= {va[L-2:0], s0_v};
  end

  always_ff @(posedge clk) begin
    ba <= {ba[L-2:0], bad0};
  end

  logic          b_v, b_bad;
  logic [CW-1:0] b_f0, b_f1, b_f2;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else     b_v <= va[L-1];
  end

  always_ff @(posedge clk) begin
    b_bad <= ba[L-1];
    b_f0  <= qa0[CW-1:0];
    b_f1  <= qa1[CW-1:0];
    b_f2  <= qa2[CW-1:0];
  end

  // k0 division.
  ibd_pkg::num_t qb;
  logic [L-1:0]  vb;
  ctxb_t         cb [L];

  ibd_div u_div_k0 (
    .clk(clk), .num(ibd_pkg::num_t'(b_f0) << FB), .den(ibd_pkg::den_t'(a00)), .quo(qb)
  );

  always_ff @(posedge clk) begin
    if (rst) vb <= '0;
    else     vb <= {vb[L-2:0], b_v};
  end

  always_ff @(posedge clk) begin
    cb[0] <= '{bad: b_bad, f1: b_f1, f2: b_f2};
    for (int i = 1; i < L; i++) cb[i] <= cb[i-1];
  end

  // Products with k0 and the residual n1.
  logic                 c0_v, c1_v, c2_v, c3_v;
  logic [K0_W-1:0]      c0_k0, c1_k0, c2_k0, c3_k0;
  logic [CW-1:0]        c0_f1, c1_f1, c0_f2, c1_f2, c2_f2, c3_f2;
  logic                 c0_bad, c1_bad, c2_bad, c3_bad;
  logic [MW-1:0]        c1_m1, c1_m2;
  logic [K0_W-1:0]      c2_m2s, c3_m2s;
  logic signed [SW-1:0] c2_n1;
  logic [SW-1:0]        n1_abs;
  logic [K0_W-1:0]      c3_mag;
  logic [MW-1:0]        c3_p12;
  logic                 c3_neg;

  assign n1_abs = mag_s(c2_n1);

  always_ff @(posedge clk) begin
    if (rst) begin
      c0_v <= 1'b0;
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
    end else begin
      c0_v <= vb[L-1];
      c1_v <= c0_v;
      c2_v <= c1_v;
      c3_v <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    c0_k0  <= (qb > TWO_N) ? TWO_K : qb[K0_W-1:0];
    c0_f1  <= cb[L-1].f1;
    c0_f2  <= cb[L-1].f2;
    c0_bad <= cb[L-1].bad;
    c1_m1  <= c0_k0 * a01;
    c1_m2  <= c0_k0 * a02;
    c1_k0  <= c0_k0;
    c1_f1  <= c0_f1;
    c1_f2  <= c0_f2;
    c1_bad <= c0_bad;
    c2_n1  <= SW'(c1_f1) - SW'(c1_m1[FB +: K0_W]);
    c2_m2s <= c1_m2[FB +: K0_W];
    c2_k0  <= c1_k0;
    c2_f2  <= c1_f2;
    c2_bad <= c1_bad;
    c3_mag <= n1_abs[K0_W-1:0];
    c3_p12 <= n1_abs[K0_W-1:0] * a12;
    c3_neg <= c2_n1[SW-1];
    c3_m2s <= c2_m2s;
    c3_k0  <= c2_k0;
    c3_f2  <= c2_f2;
    c3_bad <= c2_bad;
  end

  // k1 and the n1 share of k2, both over a11.
  ibd_pkg::num_t qk1, qt;
  logic [L-1:0]  vk;
  ctxk_t         ck [L];

  ibd_div u_div_k1 (
    .clk(clk), .num(ibd_pkg::num_t'(c3_mag) << FB), .den(ibd_pkg::den_t'(a11)), .quo(qk1)
  );
  ibd_div u_div_t (
    .clk(clk), .num(ibd_pkg::num_t'(c3_p12)), .den(ibd_pkg::den_t'(a11)), .quo(qt)
  );

  always_ff @(posedge clk) begin
    if (rst) vk <= '0;
    else     vk <= {vk[L-2:0], c3_v};
  end

  always_ff @(posedge clk) begin
    ck[0] <= '{bad: c3_bad, k0: c3_k0, f2: c3_f2, m2s: c3_m2s, neg: c3_neg};
    for (int i = 1; i < L; i++) ck[i] <= ck[i-1];
  end

  // Solved estimates and their bounds.
  logic                 d0_v, d1_v, d0_bad, d1_bad;
  logic [K0_W-1:0]      d0_k0;
  logic signed [WW-1:0] d0_k1, d0_k2, t_s;
  logic signed [SW-1:0] k0b;
  logic signed [WW-1:0] k1b, k2b;
  logic signed [SW-1:0] d1_k0, d1_k2, d1_s1;
  logic                 d1_k1neg;
  logic [CW-1:0]        d1_k1v;

  assign t_s = ck[L-1].neg ? -WW'(qt) : WW'(qt);

  always_comb begin
    k0b = SW'(d0_k0);
    k1b = d0_k1;
    k2b = d0_k2;
    if (k0b > ONE_S) begin
      k0b = ONE_S;
      k1b = '0;
      k2b = '0;
    end
    if (k1b > ONE_W) begin
      k1b = ONE_W;
      k0b = '0;
      k2b = '0;
    end
    if (k2b > ONE_W) begin
      k2b = ONE_W;
      k0b = '0;
      k1b = '0;
    end
    if (k2b < MTWO_W) k2b = MTWO_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_v <= 1'b0;
      d1_v <= 1'b0;
    end else begin
      d0_v <= vk[L-1];
      d1_v <= d0_v;
    end
  end

  always_ff @(posedge clk) begin
    d0_k0    <= ck[L-1].k0;
    d0_k1    <= ck[L-1].neg ? -WW'(qk1) : WW'(qk1);
    d0_k2    <= WW'(ck[L-1].f2) - WW'(ck[L-1].m2s) - t_s;
    d0_bad   <= ck[L-1].bad;
    d1_k0    <= k0b;
    d1_k1neg <= k1b[WW-1];
    d1_k1v   <= k1b[CW-1:0];
    d1_k2    <= k2b[SW-1:0];
    d1_s1    <= k0b + k2b[SW-1:0];
    d1_bad   <= d0_bad;
  end

  // Renormalization when k1 is negative.
  ibd_pkg::num_t qr0, qr2;
  logic [L-1:0]  vr1;
  ctxr1_t        cr1 [L];

  ibd_div u_div_r1a (
    .clk(clk), .num(ibd_pkg::num_t'(mag_s(d1_k0)) << FB),
    .den(ibd_pkg::den_t'(mag_s(d1_s1))), .quo(qr0)
  );
  ibd_div u_div_r1b (
    .clk(clk), .num(ibd_pkg::num_t'(mag_s(d1_k2)) << FB),
    .den(ibd_pkg::den_t'(mag_s(d1_s1))), .quo(qr2)
  );

  always_ff @(posedge clk) begin
    if (rst) vr1 <= '0;
    else     vr1 <= {vr1[L-2:0], d1_v};
  end

  always_ff @(posedge clk) begin
    cr1[0] <= '{bad: d1_bad, k0: d1_k0, k1neg: d1_k1neg, k1v: d1_k1v,
                k2neg: d1_k2[SW-1], sneg: d1_s1[SW-1], szero: (d1_s1 == '0)};
    for (int i = 1; i < L; i++) cr1[i] <= cr1[i-1];
  end

  logic                 e_v, e_bad, e_k2neg;
  logic signed [SW-1:0] e_k0, e_s2;
  logic [CW-1:0]        e_k1;
  logic signed [SW-1:0] k0e;
  logic [SW-1:0]        q0m;
  logic [CW-1:0]        k1e;
  logic                 k2neg_e, bad_e;

  always_comb begin
    q0m     = (qr0 > TWO_N) ? TWO_S : qr0[SW-1:0];
    bad_e   = cr1[L-1].bad;
    k0e     = cr1[L-1].k0;
    k1e     = cr1[L-1].k1v;
    k2neg_e = cr1[L-1].k2neg;
    if (cr1[L-1].k1neg) begin
      if (cr1[L-1].szero) bad_e = 1'b1;
      k0e     = cr1[L-1].sneg ? -q0m : q0m;
      k1e     = '0;
      k2neg_e = (qr2 != '0) && (cr1[L-1].k2neg ^ cr1[L-1].sneg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else     e_v <= vr1[L-1];
  end

  always_ff @(posedge clk) begin
    e_k0    <= k0e;
    e_k1    <= k1e;
    e_k2neg <= k2neg_e;
    e_bad   <= bad_e;
    e_s2    <= k0e + SW'(k1e);
  end

  // Renormalization when k2 is negative.
  ibd_pkg::num_t qs0, qs1;
  logic [L-1:0]  vr2;
  ctxr2_t        cr2 [L];

  ibd_div u_div_r2a (
    .clk(clk), .num(ibd_pkg::num_t'(mag_s(e_k0)) << FB),
    .den(ibd_pkg::den_t'(mag_s(e_s2))), .quo(qs0)
  );
  ibd_div u_div_r2b (
    .clk(clk), .num(ibd_pkg::num_t'(e_k1) << FB),
    .den(ibd_pkg::den_t'(mag_s(e_s2))), .quo(qs1)
  );

  always_ff @(posedge clk) begin
    if (rst) vr2 <= '0;
    else     vr2 <= {vr2[L-2:0], e_v};
  end

  always_ff @(posedge clk) begin
    cr2[0] <= '{bad: e_bad, k0: e_k0, k1: e_k1, k2neg: e_k2neg,
                sneg: e_s2[SW-1], szero: (e_s2 == '0)};
    for (int i = 1; i < L; i++) cr2[i] <= cr2[i-1];
  end

  logic                 f0_v, f1_v, f2_v;
  logic                 f0_bad, f1_bad, f2_bad;
  logic signed [SW-1:0] f0_k0, f1_k0, f2_k0;
  logic [CW-1:0]        f0_k1, f1_k1, f2_k1;
  logic signed [SW-1:0] k0f;
  logic [SW-1:0]        q0f;
  logic [CW-1:0]        k1f;
  logic                 bad_f;

  always_comb begin
    q0f   = (qs0 > ONE_N) ? ONE_S : qs0[SW-1:0];
    bad_f = cr2[L-1].bad;
    k1f   = cr2[L-1].k1;
    k0f   = cr2[L-1].k0;
    if (cr2[L-1].k2neg) begin
      if (cr2[L-1].szero) bad_f = 1'b1;
      k0f = (cr2[L-1].k0[SW-1] ^ cr2[L-1].sneg) ? -q0f : q0f;
      if (cr2[L-1].sneg && (qs1 != '0)) k1f = '0;
      else k1f = (qs1 > ONE_N) ? ONE_C : qs1[CW-1:0];
    end else begin
      if (k0f > ONE_S) k0f = ONE_S;
      if (k0f < -ONE_S) k0f = -ONE_S;
    end
  end

  // Triangle constraint.
  logic signed [SW-1:0] f1_k2, f1_p, k2f, pf, dv;
  logic signed [PW-1:0] f2_pp, f2_dd, f2_pd;
  logic signed [SW-1:0] f2_k2;

  assign k2f = ONE_S - f0_k0 - SW'(f0_k1);
  assign pf  = SW'(f0_k1 >> 1) + k2f;
  assign dv  = ONE_S - f1_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_v <= 1'b0;
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else begin
      f0_v <= vr2[L-1];
      f1_v <= f0_v;
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    f0_k0  <= k0f;
    f0_k1  <= k1f;
    f0_bad <= bad_f;
    f1_k0  <= f0_k0;
    f1_k1  <= f0_k1;
    f1_k2  <= k2f;
    f1_p   <= pf;
    f1_bad <= f0_bad;
    f2_pp  <= f1_p * f1_p;
    f2_dd  <= dv * dv;
    f2_pd  <= f1_p * dv;
    f2_k2  <= f1_k2;
    f2_k0  <= f1_k0;
    f2_k1  <= f1_k1;
    f2_bad <= f1_bad;
  end

  logic signed [PW-1:0] k2q, pd_abs;
  logic [SW-1:0]        pq;
  logic signed [SW-1:0] k0t, k1t;
  logic [CW-1:0]        p0_out, p1_out;

  always_comb begin
    k2q    = PW'(f2_k2) <<< FB;
    pd_abs = f2_pd[PW-1] ? -f2_pd : f2_pd;
    pq     = pd_abs[FB +: SW];
    k0t    = f2_k0;
    k1t    = SW'(f2_k1);
    if (tri_on && (f2_pp < k2q)) begin
      k0t = f2_dd[FB +: SW];
      k1t = f2_pd[PW-1] ? -(pq << 1) : (pq << 1);
    end
    if (k0t[SW-1])      p0_out = '0;
    else if (k0t > ONE_S) p0_out = ONE_C;
    else                p0_out = k0t[CW-1:0];
    if (k1t[SW-1])      p1_out = '0;
    else if (k1t > ONE_S) p1_out = ONE_C;
    else                p1_out = k1t[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= f2_v;
  end

  always_ff @(posedge clk) begin
    result_valid <= ~f2_bad;
    prob_ibd0    <= f2_bad ? '0 : p0_out;
    prob_ibd1    <= f2_bad ? '0 : p1_out;
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result_valid) |-> (prob_ibd0 == '0 && prob_ibd1 == '0))
    else $error("invalid result carries nonzero probabilities");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (prob_ibd0 <= ONE_C && prob_ibd1 <= ONE_C))
    else $error("probability above one");

endmodule

// ----- hdl/ibd_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per register stage.
module ibd_div (
  input  logic          clk,
  input  ibd_pkg::num_t num,
  input  ibd_pkg::den_t den,
  output ibd_pkg::num_t quo
);

  localparam int W = ibd_pkg::NUM_W;
  localparam int D = ibd_pkg::DEN_W;

  ibd_pkg::num_t nq [W];
  ibd_pkg::den_t rq [W];
  ibd_pkg::den_t dq [W];

  ibd_pkg::num_t n_in [W];
  ibd_pkg::den_t r_in [W];
  ibd_pkg::den_t d_in [W];
  logic [D:0]    trial [W];
  logic [D:0]    diff [W];
  ibd_pkg::num_t n_next [W];
  ibd_pkg::den_t r_next [W];

  always_comb begin
    for (int i = 0; i < W; i++) begin
      if (i == 0) begin
        n_in[i] = num;
        r_in[i] = '0;
        d_in[i] = den;
      end else begin
        n_in[i] = nq[i-1];
        r_in[i] = rq[i-1];
        d_in[i] = dq[i-1];
      end
      trial[i] = {r_in[i], n_in[i][W-1]};
      diff[i]  = trial[i] - {1'b0, d_in[i]};
      if (trial[i] >= {1'b0, d_in[i]}) begin
        r_next[i] = diff[i][D-1:0];
        n_next[i] = {n_in[i][W-2:0], 1'b1};
      end else begin
        r_next[i] = trial[i][D-1:0];
        n_next[i] = {n_in[i][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < W; i++) begin
      nq[i] <= n_next[i];
      rq[i] <= r_next[i];
      dq[i] <= d_in[i];
    end
  end

  assign quo = nq[W-1];

endmodule
